/* hdl/tcmf_pkg.sv */
// Shared types, constants and arithmetic helpers for the thruster command mixer.
`timescale 1ns / 1ps
`default_nettype none

package tcmf_pkg;

    localparam int PW = 11;          // pulse width field
    localparam int QDEPTH = 2;       // front-to-back queue depth
    localparam int QAW = $clog2(QDEPTH);
    localparam int QCW = $clog2(QDEPTH + 1);

    // configuration register indexes
    localparam logic [2:0] CFG_TIMEOUT  = 3'd0;
    localparam logic [2:0] CFG_DEADZONE = 3'd1;
    localparam logic [2:0] CFG_START    = 3'd2;
    localparam logic [2:0] CFG_STOP     = 3'd3;
    localparam logic [2:0] CFG_NEUTRAL  = 3'd4;

    localparam logic [15:0] RST_TIMEOUT  = 16'd1200;
    localparam logic [6:0]  RST_DEADZONE = 7'd5;
    localparam logic [7:0]  RST_START    = 8'hAA;
    localparam logic [7:0]  RST_STOP     = 8'h55;
    localparam logic [10:0] RST_NEUTRAL  = 11'd1500;

    // input item kinds and result causes
    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_TICK = 1'b1;
    localparam logic CAUSE_FRAME    = 1'b0;
    localparam logic CAUSE_FAILSAFE = 1'b1;

    localparam logic signed [7:0] AXIS_MAX = 8'sd100;
    localparam logic signed [7:0] AXIS_MIN = -8'sd100;
    localparam logic signed [12:0] PULSE_MAX = 13'sd2047;

    typedef struct packed {
        logic [15:0]   timeout_ms;
        logic [6:0]    deadzone;
        logic [7:0]    start_marker;
        logic [7:0]    stop_marker;
        logic [PW-1:0] neutral_us;
    } t_cfg;

    // one job handed from front to back
    typedef struct packed {
        logic       cause;
        logic [7:0] surge;
        logic [7:0] sway;
        logic [7:0] yaw;
        logic [7:0] heave;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    function automatic logic [7:0] magnitude(input logic [7:0] v);
        magnitude = v[7] ? (~v + 8'd1) : v;
    endfunction

    // deadzone on raw magnitude, clamp to +/-100, times four
    function automatic logic signed [PW-1:0] axis_delta(input logic [7:0] v,
                                                        input logic [6:0] dz);
        logic signed [7:0] c;
        c = $signed(v);
        if (magnitude(v) < {1'b0, dz}) begin
            c = 8'sd0;
        end else if (c > AXIS_MAX) begin
            c = AXIS_MAX;
        end else if (c < AXIS_MIN) begin
            c = AXIS_MIN;
        end
        axis_delta = $signed({c[7], c, 2'b00});
    endfunction

    function automatic logic [PW-1:0] pulse(input logic [PW-1:0] neutral,
                                            input logic signed [PW-1:0] d);
        logic signed [12:0] p;
        p = $signed({2'b00, neutral}) + $signed({{2{d[PW-1]}}, d});
        if (p < 13'sd0) begin
            pulse = '0;
        end else if (p > PULSE_MAX) begin
            pulse = PULSE_MAX[PW-1:0];
        end else begin
            pulse = p[PW-1:0];
        end
    endfunction

endpackage

`default_nettype wire

/* hdl/thruster_command_mixer_failsafe_top.sv */
// Top level of the thruster command mixer with failsafe timeout.
//
// Input channel (i_valid/o_ready): one word per item, either a received serial
// byte (i_kind = 0, i_rx_byte) or a one millisecond tick (i_kind = 1).
// Bytes form fixed six-byte frames counted from reset: start marker, surge,
// sway, yaw, heave, stop marker. A frame with both markers right yields one
// result word with eight ESC pulse widths and cause 0; a tick that brings the
// idle count up to timeout_ms yields an all-neutral word with cause 1.
// Output channel (o_valid/i_ready): result words, in item order.
// Config channel (i_cfg_valid/o_cfg_ready, always ready): i_cfg_index picks
// timeout_ms, deadzone, start_marker, stop_marker or neutral_us; write only
// while the block is idle.
// Throughput: one item per cycle while the job queue is not full. A result word
// passes through the job queue (written on the taking edge) and then the output
// register (loaded when the back end pops the queue) before it shows on the output.
// The front end keeps taking items while the output is stalled, until its
// two-entry job queue fills; o_ready then drops until the receiver takes a word.
// Reset (synchronous, active low): registers return to their defaults, frame
// position and idle count clear, queue and output register empty.
`timescale 1ns / 1ps
`default_nettype none

module thruster_command_mixer_failsafe_top (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    // items
    input  wire                       i_valid,
    output logic                      o_ready,
    input  wire                       i_kind,
    input  wire  [7:0]                i_rx_byte,
    // results
    output logic                      o_valid,
    input  wire                       i_ready,
    output logic                      o_cause,
    output logic [tcmf_pkg::PW-1:0]   o_front_right_us,
    output logic [tcmf_pkg::PW-1:0]   o_front_left_us,
    output logic [tcmf_pkg::PW-1:0]   o_rear_right_us,
    output logic [tcmf_pkg::PW-1:0]   o_rear_left_us,
    output logic [tcmf_pkg::PW-1:0]   o_vert_front_right_us,
    output logic [tcmf_pkg::PW-1:0]   o_vert_front_left_us,
    output logic [tcmf_pkg::PW-1:0]   o_vert_rear_right_us,
    output logic [tcmf_pkg::PW-1:0]   o_vert_rear_left_us,
    // configuration writes
    input  wire                       i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire  [2:0]                i_cfg_index,
    input  wire  [15:0]               i_cfg_data
);
    import tcmf_pkg::*;

    t_cfg   r_cfg;
    t_qstat qstat;
    t_job   push_job;
    t_job   head_job;
    logic   push;
    logic   pop;

    assign o_cfg_ready = 1'b1;

    // Config registers; an unknown index is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.timeout_ms   <= RST_TIMEOUT;
            r_cfg.deadzone     <= RST_DEADZONE;
            r_cfg.start_marker <= RST_START;
            r_cfg.stop_marker  <= RST_STOP;
            r_cfg.neutral_us   <= RST_NEUTRAL;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_TIMEOUT:  r_cfg.timeout_ms   <= i_cfg_data;
                CFG_DEADZONE: r_cfg.deadzone     <= i_cfg_data[6:0];
                CFG_START:    r_cfg.start_marker <= i_cfg_data[7:0];
                CFG_STOP:     r_cfg.stop_marker  <= i_cfg_data[7:0];
                CFG_NEUTRAL:  r_cfg.neutral_us   <= i_cfg_data[PW-1:0];
                default: begin
                end
            endcase
        end
    end

    // Front end: framing and failsafe timer decide which words are produced.
    tcmf_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_kind    (i_kind),
        .i_rx_byte (i_rx_byte),
        .i_cfg     (r_cfg),
        .i_qstat   (qstat),
        .o_push    (push),
        .o_job     (push_job)
    );

    // Decouples the front end from output stalls.
    tcmf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_job   (head_job),
        .o_qstat (qstat)
    );

    // Back end: mixing into pulse widths, registered output.
    tcmf_back u_back (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cfg                 (r_cfg),
        .i_qstat               (qstat),
        .i_job                 (head_job),
        .o_pop                 (pop),
        .o_valid               (o_valid),
        .i_ready               (i_ready),
        .o_cause               (o_cause),
        .o_front_right_us      (o_front_right_us),
        .o_front_left_us       (o_front_left_us),
        .o_rear_right_us       (o_rear_right_us),
        .o_rear_left_us        (o_rear_left_us),
        .o_vert_front_right_us (o_vert_front_right_us),
        .o_vert_front_left_us  (o_vert_front_left_us),
        .o_vert_rear_right_us  (o_vert_rear_right_us),
        .o_vert_rear_left_us   (o_vert_rear_left_us)
    );

endmodule

`default_nettype wire

/* hdl/tcmf_front.sv */
// Front end: frame assembly, marker check and idle timeout, emits jobs.
`timescale 1ns / 1ps
`default_nettype none

module tcmf_front (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    output logic                 o_ready,
    input  wire                  i_kind,
    input  wire  [7:0]           i_rx_byte,
    input  tcmf_pkg::t_cfg       i_cfg,
    input  tcmf_pkg::t_qstat     i_qstat,
    output logic                 o_push,
    output tcmf_pkg::t_job       o_job
);
    import tcmf_pkg::*;

    logic [2:0]  r_pos, n_pos;
    logic [7:0]  r_start, n_start;
    logic [15:0] r_idle, n_idle;
    logic [7:0]  r_axis [4];
    logic [16:0] idle_inc;
    logic        accept;
    logic        axis_we;

    assign o_ready  = !i_qstat.full;
    assign accept   = i_valid && o_ready;
    assign idle_inc = {1'b0, r_idle} + 17'd1;

    always_comb begin
        n_pos   = r_pos;
        n_start = r_start;
        n_idle  = r_idle;
        axis_we = 1'b0;
        o_push  = 1'b0;
        o_job.cause = CAUSE_FRAME;
        o_job.surge = r_axis[0];
        o_job.sway  = r_axis[1];
        o_job.yaw   = r_axis[2];
        o_job.heave = r_axis[3];
        if (accept) begin
            if (i_kind == KIND_TICK) begin
                if (idle_inc >= {1'b0, i_cfg.timeout_ms}) begin
                    n_idle      = '0;
                    o_push      = 1'b1;
                    o_job.cause = CAUSE_FAILSAFE;
                end else begin
                    n_idle = idle_inc[15:0];
                end
            end else begin
                case (r_pos)
                    3'd1, 3'd2, 3'd3, 3'd4: begin
                        axis_we = 1'b1;
                        n_pos   = r_pos + 3'd1;
                    end
                    3'd5: begin
                        n_pos = '0;
                        if (r_start == i_cfg.start_marker && i_rx_byte == i_cfg.stop_marker) begin
                            n_idle = '0;
                            o_push = 1'b1;
                        end
                    end
                    default: begin
                        // start byte; stray positions restart the frame
                        n_start = i_rx_byte;
                        n_pos   = 3'd1;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_start <= '0;
            r_idle  <= '0;
        end else begin
            r_pos   <= n_pos;
            r_start <= n_start;
            r_idle  <= n_idle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (axis_we) begin
            r_axis[2'(r_pos - 3'd1)] <= i_rx_byte;
        end
    end

endmodule

`default_nettype wire

/* hdl/tcmf_queue.sv */
// Short job queue between front end and mixer back end.
`timescale 1ns / 1ps
`default_nettype none

module tcmf_queue (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_push,
    input  tcmf_pkg::t_job       i_job,
    input  wire                  i_pop,
    output tcmf_pkg::t_job       o_job,
    output tcmf_pkg::t_qstat     o_qstat
);
    import tcmf_pkg::*;

    t_job           r_mem [QDEPTH];
    logic [QAW-1:0] r_wptr;
    logic [QAW-1:0] r_rptr;
    logic [QCW-1:0] r_count;
    logic           do_push;
    logic           do_pop;

    assign o_qstat.full  = (r_count == QCW'(QDEPTH));
    assign o_qstat.empty = (r_count == '0);
    assign do_push = i_push && !o_qstat.full;
    assign do_pop  = i_pop && !o_qstat.empty;
    assign o_job   = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == QAW'(QDEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == QAW'(QDEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

endmodule

`default_nettype wire

/* hdl/tcmf_back.sv */
// Back end: axis selection, deadzone/clamp, pulse mixing and output register.
`timescale 1ns / 1ps
`default_nettype none

module tcmf_back (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  tcmf_pkg::t_cfg            i_cfg,
    input  tcmf_pkg::t_qstat          i_qstat,
    input  tcmf_pkg::t_job            i_job,
    output logic                      o_pop,
    output logic                      o_valid,
    input  wire                       i_ready,
    output logic                      o_cause,
    output logic [tcmf_pkg::PW-1:0]   o_front_right_us,
    output logic [tcmf_pkg::PW-1:0]   o_front_left_us,
    output logic [tcmf_pkg::PW-1:0]   o_rear_right_us,
    output logic [tcmf_pkg::PW-1:0]   o_rear_left_us,
    output logic [tcmf_pkg::PW-1:0]   o_vert_front_right_us,
    output logic [tcmf_pkg::PW-1:0]   o_vert_front_left_us,
    output logic [tcmf_pkg::PW-1:0]   o_vert_rear_right_us,
    output logic [tcmf_pkg::PW-1:0]   o_vert_rear_left_us
);
    import tcmf_pkg::*;

    logic                 r_valid;
    logic [PW-1:0]        n_pw [8];
    logic [PW-1:0]        r_pw [8];
    logic                 r_cause;
    logic [7:0]           m_su, m_sw, m_ya;
    logic [7:0]           sel;
    logic signed [PW-1:0] d, h;
    logic [PW-1:0]        pp, pn, hp, hn;
    logic                 sel_surge, sel_sway;

    assign o_pop = !i_qstat.empty && (!r_valid || i_ready);

    always_comb begin
        m_su = magnitude(i_job.surge);
        m_sw = magnitude(i_job.sway);
        m_ya = magnitude(i_job.yaw);
        // ties favour surge, then sway
        sel_surge = (m_su >= m_sw) && (m_su >= m_ya);
        sel_sway  = !sel_surge && (m_sw >= m_ya);
        sel = sel_surge ? i_job.surge : (sel_sway ? i_job.sway : i_job.yaw);
        d  = axis_delta(sel, i_cfg.deadzone);
        h  = axis_delta(i_job.heave, i_cfg.deadzone);
        pp = pulse(i_cfg.neutral_us, d);
        pn = pulse(i_cfg.neutral_us, -d);
        hp = pulse(i_cfg.neutral_us, h);
        hn = pulse(i_cfg.neutral_us, -h);

        if (i_job.cause == CAUSE_FAILSAFE) begin
            for (int k = 0; k < 8; k++) begin
                n_pw[k] = i_cfg.neutral_us;
            end
        end else begin
            if (sel_surge) begin
                n_pw[0] = pp; n_pw[1] = pp; n_pw[2] = pn; n_pw[3] = pn;
            end else if (sel_sway) begin
                n_pw[0] = pn; n_pw[1] = pp; n_pw[2] = pn; n_pw[3] = pp;
            end else begin
                n_pw[0] = pn; n_pw[1] = pp; n_pw[2] = pp; n_pw[3] = pn;
            end
            n_pw[4] = hp; n_pw[5] = hn; n_pw[6] = hn; n_pw[7] = hp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cause <= i_job.cause;
            r_pw    <= n_pw;
        end
    end

    assign o_valid               = r_valid;
    assign o_cause               = r_cause;
    assign o_front_right_us      = r_pw[0];
    assign o_front_left_us       = r_pw[1];
    assign o_rear_right_us       = r_pw[2];
    assign o_rear_left_us        = r_pw[3];
    assign o_vert_front_right_us = r_pw[4];
    assign o_vert_front_left_us  = r_pw[5];
    assign o_vert_rear_right_us  = r_pw[6];
    assign o_vert_rear_left_us   = r_pw[7];

endmodule

`default_nettype wire

/* hdl/tcmf_checker.sv */
// Port-level checker for the thruster mixer, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module tcmf_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        o_valid,
    input wire        i_ready,
    input wire        o_cause,
    input wire [10:0] o_front_right_us,
    input wire [10:0] o_front_left_us,
    input wire [10:0] o_rear_right_us,
    input wire [10:0] o_rear_left_us,
    input wire [10:0] o_vert_front_right_us,
    input wire [10:0] o_vert_front_left_us,
    input wire [10:0] o_vert_rear_right_us,
    input wire [10:0] o_vert_rear_left_us
);

    // stalled result word holds its cause, front right and vertical front right widths
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_cause)
            && $stable(o_front_right_us) && $stable(o_vert_front_right_us))
        else $error("result word changed while stalled");

    // no word straight out of reset
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    // failsafe drives every thruster to the same neutral width
    a_failsafe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_cause |->
            o_front_right_us == o_front_left_us && o_front_right_us == o_rear_right_us
            && o_front_right_us == o_rear_left_us
            && o_front_right_us == o_vert_front_right_us
            && o_front_right_us == o_vert_front_left_us
            && o_front_right_us == o_vert_rear_right_us
            && o_front_right_us == o_vert_rear_left_us)
        else $error("failsafe word not uniform");

    // heave pairs: front right with rear left, front left with rear right
    a_vert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_vert_front_right_us == o_vert_rear_left_us
            && o_vert_front_left_us == o_vert_rear_right_us)
        else $error("vertical pairing broken");

    // one horizontal axis only: thrusters pair up in one of three ways
    a_horiz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |->
            (o_front_right_us == o_front_left_us && o_rear_right_us == o_rear_left_us)
            || (o_front_right_us == o_rear_right_us && o_front_left_us == o_rear_left_us)
            || (o_front_right_us == o_rear_left_us && o_front_left_us == o_rear_right_us))
        else $error("horizontal mix fits no single axis");

endmodule

bind thruster_command_mixer_failsafe_top tcmf_checker u_tcmf_checker (
    .i_clk                 (i_clk),
    .i_rst_n               (i_rst_n),
    .o_valid               (o_valid),
    .i_ready               (i_ready),
    .o_cause               (o_cause),
    .o_front_right_us      (o_front_right_us),
    .o_front_left_us       (o_front_left_us),
    .o_rear_right_us       (o_rear_right_us),
    .o_rear_left_us        (o_rear_left_us),
    .o_vert_front_right_us (o_vert_front_right_us),
    .o_vert_front_left_us  (o_vert_front_left_us),
    .o_vert_rear_right_us  (o_vert_rear_right_us),
    .o_vert_rear_left_us   (o_vert_rear_left_us)
);

`default_nettype wire
